// ----- hdl/ithe_pkg.sv -----
`default_nettype none

package ithe_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } ithe_in_t;

  typedef struct packed {
    logic        status;
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [7:0]  protocol;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [31:0] sequence_number;
    logic [31:0] ack_number;
    logic [7:0]  flag_bits;
    logic [7:0]  icmp_kind;
    logic [6:0]  payload_offset;
  } ithe_out_t;

  typedef struct packed {
    logic [6:0]  byte_position;
    logic [3:0]  ip_header_words;
    logic [7:0]  proto_reg;
    logic [31:0] src_addr_reg;
    logic [31:0] dst_addr_reg;
    logic [15:0] src_port_reg;
    logic [15:0] dst_port_reg;
    logic [31:0] seq_reg;
    logic [31:0] ack_reg;
    logic [7:0]  flags_reg;
    logic [3:0]  tcp_header_words;
    logic [7:0]  icmp_type_reg;
  } ithe_state_t;

  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;

  localparam logic [6:0] POS_MAX   = 7'd127;
  localparam logic [6:0] POS_IHL   = 7'd0;
  localparam logic [6:0] POS_PROTO = 7'd9;
  localparam logic [6:0] POS_SRC   = 7'd12;
  localparam logic [6:0] POS_SRC_E = 7'd15;
  localparam logic [6:0] POS_DST   = 7'd16;
  localparam logic [6:0] POS_DST_E = 7'd19;

  localparam logic [6:0] REL_SPORT_E = 7'd1;
  localparam logic [6:0] REL_DPORT_E = 7'd3;
  localparam logic [6:0] REL_SEQ_E   = 7'd7;
  localparam logic [6:0] REL_ACK_E   = 7'd11;
  localparam logic [6:0] REL_DOFF    = 7'd12;
  localparam logic [6:0] REL_FLAGS   = 7'd13;

  localparam logic [7:0] IP_MIN_BYTES  = 8'd20;
  localparam logic [7:0] TCP_MIN_BYTES = 8'd20;
  localparam logic [7:0] UDP_BYTES     = 8'd8;
  localparam logic [7:0] ICMP_BYTES    = 8'd1;
  localparam logic [6:0] PAYLOAD_MAX   = 7'd120;

  function automatic logic [31:0] put_lane32(input logic [31:0] word,
                                             input logic [1:0] lane,
                                             input logic [7:0] b);
    logic [31:0] w;
    w = word;
    w[{~lane, 3'b000} +: 8] = b;
    return w;
  endfunction

  function automatic logic [15:0] put_lane16(input logic [15:0] word,
                                             input logic lane,
                                             input logic [7:0] b);
    logic [15:0] w;
    w = word;
    w[{~lane, 3'b000} +: 8] = b;
    return w;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/ithe_capture.sv -----
`default_nettype none

module ithe_capture (
  input  ithe_pkg::ithe_state_t st_i,
  input  ithe_pkg::ithe_in_t    item_i,
  output ithe_pkg::ithe_state_t st_next_o,
  output ithe_pkg::ithe_out_t   res_o
);
  import ithe_pkg::*;

  ithe_state_t upd;
  logic [6:0]  p;
  logic [7:0]  b;
  logic [5:0]  t;
  logic [6:0]  rel;
  logic        is_tcp;
  logic        is_udp;
  logic        is_icmp;
  logic [7:0]  need_tr;
  logic [7:0]  need;
  logic [7:0]  got;
  logic [6:0]  off;

  always_comb begin
    upd = st_i;
    p   = st_i.byte_position;
    b   = item_i.data_byte;

    if (p == POS_IHL) begin
      upd.ip_header_words = b[3:0];
    end
    t = {upd.ip_header_words, 2'b00};

    if (p == POS_PROTO) begin
      upd.proto_reg = b;
    end
    if (p >= POS_SRC && p <= POS_SRC_E) begin
      upd.src_addr_reg = put_lane32(st_i.src_addr_reg, p[1:0], b);
    end
    if (p >= POS_DST && p <= POS_DST_E) begin
      upd.dst_addr_reg = put_lane32(st_i.dst_addr_reg, p[1:0], b);
    end

    rel = p - {1'b0, t};
    if (p >= {1'b0, t}) begin
      if (rel == 7'd0) begin
        upd.icmp_type_reg = b;
      end
      if (rel <= REL_SPORT_E) begin
        upd.src_port_reg = put_lane16(st_i.src_port_reg, rel[0], b);
      end else if (rel <= REL_DPORT_E) begin
        upd.dst_port_reg = put_lane16(st_i.dst_port_reg, rel[0], b);
      end else if (rel <= REL_SEQ_E) begin
        upd.seq_reg = put_lane32(st_i.seq_reg, rel[1:0], b);
      end else if (rel <= REL_ACK_E) begin
        upd.ack_reg = put_lane32(st_i.ack_reg, rel[1:0], b);
      end else if (rel == REL_DOFF) begin
        upd.tcp_header_words = b[7:4];
      end else if (rel == REL_FLAGS) begin
        upd.flags_reg = b;
      end
    end

    if (p != POS_MAX) begin
      upd.byte_position = p + 7'd1;
    end

    is_tcp  = (upd.proto_reg == PROTO_TCP);
    is_udp  = (upd.proto_reg == PROTO_UDP);
    is_icmp = (upd.proto_reg == PROTO_ICMP);

    if (is_tcp) begin
      need_tr = TCP_MIN_BYTES;
    end else if (is_udp) begin
      need_tr = UDP_BYTES;
    end else if (is_icmp) begin
      need_tr = ICMP_BYTES;
    end else begin
      need_tr = 8'd0;
    end
    need = {2'b00, t} + need_tr;
    if (need < IP_MIN_BYTES) begin
      need = IP_MIN_BYTES;
    end
    got = {1'b0, p} + 8'd1;

    if (is_tcp) begin
      off = {1'b0, t} + {1'b0, upd.tcp_header_words, 2'b00};
    end else if (is_udp) begin
      off = {1'b0, t} + UDP_BYTES[6:0];
    end else begin
      off = {1'b0, t};
    end

    res_o.status          = (got < need);
    res_o.source_address  = upd.src_addr_reg;
    res_o.dest_address    = upd.dst_addr_reg;
    res_o.protocol        = upd.proto_reg;
    res_o.source_port     = (is_tcp || is_udp) ? upd.src_port_reg : 16'd0;
    res_o.dest_port       = (is_tcp || is_udp) ? upd.dst_port_reg : 16'd0;
    res_o.sequence_number = is_tcp ? upd.seq_reg : 32'd0;
    res_o.ack_number      = is_tcp ? upd.ack_reg : 32'd0;
    res_o.flag_bits       = is_tcp ? upd.flags_reg : 8'd0;
    res_o.icmp_kind       = is_icmp ? upd.icmp_type_reg : 8'd0;
    res_o.payload_offset  = off;

    st_next_o = item_i.last_byte ? '0 : upd;
  end

endmodule

`default_nettype wire

// ----- hdl/ipv4_transport_header_extractor_unit.sv -----
// Channel  Direction  Handshake               Payload
// in       input      in_valid_i / in_stall_o   in_data_i  (one packet byte)
// out      output     out_valid_o / out_stall_i out_data_o (one result per packet)
//
// One byte can be accepted in every cycle; the input stalls only while a last byte
// in the input register finds the result register full and stalled.
// A result becomes valid once its last byte has reached the input register and the capture
// logic loads it from the input register into the result register.
// Reset clears the byte position and all captured fields; a last byte also clears them.
// In that one case the input stall follows the output stall in the same cycle.
`default_nettype none

module ipv4_transport_header_extractor_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ithe_pkg::ithe_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ithe_pkg::ithe_out_t out_data_o
);
  import ithe_pkg::*;

  logic        s1_valid_q;
  ithe_in_t    s1_q;
  ithe_state_t st_q;
  ithe_state_t st_d;
  logic        out_valid_q;
  ithe_out_t   out_q;
  ithe_out_t   res;
  logic        out_free;
  logic        s1_adv;
  logic        s1_done;

  ithe_capture u_capture (
    .st_i      (st_q),
    .item_i    (s1_q),
    .st_next_o (st_d),
    .res_o     (res)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && (!s1_q.last_byte || out_free);
  assign s1_done    = s1_adv && s1_q.last_byte;
  assign in_stall_o = s1_valid_q && !s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      st_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (s1_adv) begin
        st_q <= st_d;
      end
      if (out_free) begin
        out_valid_q <= s1_done;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_q <= in_data_i;
    end
    if (s1_done) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && s1_q.last_byte && out_valid_q))
    else $error("input stalled without a blocked last byte");

  a_result_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q && s1_q.last_byte))
    else $error("result appeared without a last byte");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_done |=> (st_q == '0))
    else $error("state not cleared after a packet");

  a_offset_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.payload_offset <= PAYLOAD_MAX))
    else $error("payload offset out of range");

endmodule

`default_nettype wire

// ----- tb/ipv4_transport_header_extractor_unit_checker.sv -----
`timescale 1ns / 100ps

module ipv4_transport_header_extractor_unit_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  ithe_pkg::ithe_in_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  ithe_pkg::ithe_out_t out_data_i,
  output int                  fail_count_o,
  output int                  pending_o,
  output int                  results_o,
  output int                  truncated_o
);
  import ithe_pkg::*;

  ithe_state_t hdr = '0;
  ithe_out_t   expected_headers[$];
  int          mismatches = 0;

  function automatic bit absorb_byte(input ithe_in_t item, output ithe_out_t res);
    logic [7:0] b;
    int         pos;
    int         t;
    int         rel;
    int         need;
    int         off;
    bit         tcp;
    bit         udp;
    bit         icmp;
    b   = item.data_byte;
    pos = int'(hdr.byte_position);
    res = '0;
    if (pos == POS_IHL) hdr.ip_header_words = b[3:0];
    t = int'(hdr.ip_header_words) * 4;
    if (pos == POS_PROTO) hdr.proto_reg = b;
    if (pos >= POS_SRC && pos <= POS_SRC_E) hdr.src_addr_reg[8 * (15 - pos) +: 8] = b;
    if (pos >= POS_DST && pos <= POS_DST_E) hdr.dst_addr_reg[8 * (19 - pos) +: 8] = b;
    if (pos >= t) begin
      rel = pos - t;
      if (rel == 0) hdr.icmp_type_reg = b;
      if (rel <= REL_SPORT_E) hdr.src_port_reg[8 * (1 - rel) +: 8] = b;
      else if (rel <= REL_DPORT_E) hdr.dst_port_reg[8 * (3 - rel) +: 8] = b;
      else if (rel <= REL_SEQ_E) hdr.seq_reg[8 * (7 - rel) +: 8] = b;
      else if (rel <= REL_ACK_E) hdr.ack_reg[8 * (11 - rel) +: 8] = b;
      else if (rel == REL_DOFF) hdr.tcp_header_words = b[7:4];
      else if (rel == REL_FLAGS) hdr.flags_reg = b;
    end
    if (hdr.byte_position != POS_MAX) hdr.byte_position = hdr.byte_position + 7'd1;
    if (!item.last_byte) return 1'b0;

    tcp  = hdr.proto_reg == PROTO_TCP;
    udp  = hdr.proto_reg == PROTO_UDP;
    icmp = hdr.proto_reg == PROTO_ICMP;
    need = t + (tcp ? int'(TCP_MIN_BYTES) : udp ? int'(UDP_BYTES) :
                icmp ? int'(ICMP_BYTES) : 0);
    if (need < int'(IP_MIN_BYTES)) need = int'(IP_MIN_BYTES);
    if (tcp) off = t + 4 * int'(hdr.tcp_header_words);
    else if (udp) off = t + int'(UDP_BYTES);
    else off = t;

    res.status          = (pos + 1) < need;
    res.source_address  = hdr.src_addr_reg;
    res.dest_address    = hdr.dst_addr_reg;
    res.protocol        = hdr.proto_reg;
    res.source_port     = (tcp || udp) ? hdr.src_port_reg : 16'd0;
    res.dest_port       = (tcp || udp) ? hdr.dst_port_reg : 16'd0;
    res.sequence_number = tcp ? hdr.seq_reg : 32'd0;
    res.ack_number      = tcp ? hdr.ack_reg : 32'd0;
    res.flag_bits       = tcp ? hdr.flags_reg : 8'd0;
    res.icmp_kind       = icmp ? hdr.icmp_type_reg : 8'd0;
    res.payload_offset  = off[6:0];
    hdr = '0;
    return 1'b1;
  endfunction

  task automatic compare_field(input string field, input logic [31:0] want,
                               input logic [31:0] seen);
    if (want !== seen) begin
      if (mismatches < 10) begin
        $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, seen);
      end
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    ithe_out_t want;
    ithe_out_t predicted;
    if (!rst_ni) begin
      hdr = '0;
      expected_headers.delete();
      pending_o    <= 0;
      results_o    <= 0;
      truncated_o  <= 0;
      fail_count_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_headers.size() == 0) begin
          if (mismatches < 10) begin
            $display("%0t: result with nothing expected: %h", $time, out_data_i);
          end
          mismatches++;
        end else begin
          want = expected_headers.pop_front();
          compare_field("status", want.status, out_data_i.status);
          compare_field("source_address", want.source_address, out_data_i.source_address);
          compare_field("dest_address", want.dest_address, out_data_i.dest_address);
          compare_field("protocol", want.protocol, out_data_i.protocol);
          compare_field("source_port", want.source_port, out_data_i.source_port);
          compare_field("dest_port", want.dest_port, out_data_i.dest_port);
          compare_field("sequence_number", want.sequence_number,
                        out_data_i.sequence_number);
          compare_field("ack_number", want.ack_number, out_data_i.ack_number);
          compare_field("flag_bits", want.flag_bits, out_data_i.flag_bits);
          compare_field("icmp_kind", want.icmp_kind, out_data_i.icmp_kind);
          compare_field("payload_offset", want.payload_offset, out_data_i.payload_offset);
          results_o   <= results_o + 1;
          truncated_o <= truncated_o + int'(want.status);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (absorb_byte(in_data_i, predicted)) expected_headers.push_back(predicted);
      end
      pending_o    <= expected_headers.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

// ----- tb/ipv4_transport_header_extractor_unit_tb.sv -----
`timescale 1ns / 100ps

module ipv4_transport_header_extractor_unit_tb;
  import ithe_pkg::*;

  logic      clk;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  ithe_in_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  ithe_out_t out_data;

  int         fail_count;
  int         pending;
  int         results;
  int         truncated;
  int         burst_left = 0;
  int         hold_requests = 0;
  int         bytes_sent = 0;
  int         packets_sent = 0;
  logic [7:0] pkt[$];

  ipv4_transport_header_extractor_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  ipv4_transport_header_extractor_unit_checker header_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .results_o    (results),
    .truncated_o  (truncated)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3ms;
    $display("ipv4_transport_header_extractor_unit regression: fail");
    $finish;
  end

  initial begin
    int served;
    int mode;
    int span;
    served = 0;
    @(posedge rst_n);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 200);
      repeat (span) begin
        @(negedge clk);
        if (hold_requests != served) begin
          served++;
          out_stall = 1'b1;
          repeat (300) @(negedge clk);
        end
        case (mode)
          0: out_stall = 1'b0;
          1: out_stall = $urandom_range(0, 99) < 30;
          2: out_stall = $urandom_range(0, 99) < 75;
          default: out_stall = ~out_stall;
        endcase
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid = 1'b1;
    in_data = '{data_byte: b, last_byte: last};
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    bytes_sent++;
  endtask

  function automatic int min_packet_len(input int ihl, input logic [7:0] proto);
    int need;
    need = ihl * 4 + (proto == PROTO_TCP ? int'(TCP_MIN_BYTES) :
                      proto == PROTO_UDP ? int'(UDP_BYTES) :
                      proto == PROTO_ICMP ? int'(ICMP_BYTES) : 0);
    return need < int'(IP_MIN_BYTES) ? int'(IP_MIN_BYTES) : need;
  endfunction

  // Fill 0 gives random bytes with the header fields patched in, 1 all zeros,
  // 2 all ones, 3 raw random bytes.
  task automatic send_packet(input int ihl, input logic [7:0] proto, input int len,
                             input logic [3:0] doff, input int fill);
    int t;
    t = ihl * 4;
    pkt.delete();
    for (int i = 0; i < len; i++) begin
      pkt.push_back(fill == 1 ? 8'h00 : fill == 2 ? 8'hFF : 8'($urandom));
    end
    if (fill == 0) begin
      pkt[0] = {pkt[0][7:4], 4'(ihl)};
      if (len > 9) pkt[9] = proto;
      if (t + 12 < len) pkt[t + 12] = {doff, pkt[t + 12][3:0]};
    end
    foreach (pkt[i]) send_byte(pkt[i], i == pkt.size() - 1);
    packets_sent++;
  endtask

  task automatic send_random_packet();
    int         r;
    int         ihl;
    int         len;
    int         fill;
    logic [7:0] proto;
    logic [3:0] doff;
    r = $urandom_range(0, 9);
    proto = r < 3 ? PROTO_TCP : r < 6 ? PROTO_UDP : r < 8 ? PROTO_ICMP : 8'($urandom);
    ihl = 5 + (($urandom_range(0, 3) == 0) ? $urandom_range(0, 10) : 0);
    doff = ($urandom_range(0, 2) == 0) ? 4'($urandom) : 4'd5;
    fill = 0;
    r = $urandom_range(0, 99);
    if (r < 65) begin
      len = min_packet_len(ihl, proto) + $urandom_range(0, 12);
    end else if (r < 80) begin
      len = $urandom_range(1, min_packet_len(ihl, proto) - 1);
    end else if (r < 88) begin
      ihl = $urandom_range(0, 4);
      len = $urandom_range(1, 40);
    end else if (r < 92) begin
      len = $urandom_range(120, 160);
    end else begin
      len = $urandom_range(1, 30);
      fill = 3;
    end
    send_packet(ihl, proto, len, doff, fill);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    int directed;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    send_packet(5, PROTO_TCP, 40, 4'd5, 0);
    send_packet(15, PROTO_TCP, 120, 4'd15, 0);
    send_packet(5, PROTO_UDP, 28, 4'd0, 0);
    send_packet(15, PROTO_UDP, 68, 4'd0, 0);
    send_packet(5, PROTO_ICMP, 21, 4'd0, 0);
    send_packet(5, PROTO_ICMP, 20, 4'd0, 0);
    send_packet(5, 8'd0, 20, 4'd0, 0);
    send_packet(0, PROTO_TCP, 20, 4'd5, 0);
    send_packet(4, PROTO_UDP, 24, 4'd0, 0);
    send_packet(5, PROTO_TCP, 1, 4'd5, 0);
    send_packet(5, PROTO_TCP, 30, 4'd5, 0);
    send_packet(5, PROTO_UDP, 140, 4'd0, 0);
    send_packet(5, 8'd0, 20, 4'd0, 1);
    send_packet(5, 8'd0, 64, 4'd0, 2);
    directed = packets_sent;
    wait_drained();

    while (bytes_sent < 1800 || packets_sent < directed + 50) begin
      if (packets_sent == directed + 8) hold_requests++;
      if (packets_sent == directed + 30) wait_drained();
      send_random_packet();
    end
    in_valid = 1'b0;

    for (int n = 0; n < 20000 && pending != 0; n++) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Sent %0d packets in %0d bytes; %0d results checked, %0d of them truncated.",
             packets_sent, bytes_sent, results, truncated);
    if (fail_count == 0 && pending == 0) begin
      $display("ipv4_transport_header_extractor_unit regression: pass");
    end else begin
      $display("ipv4_transport_header_extractor_unit regression: fail");
    end
    $finish;
  end

endmodule
